// File: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// shared constants and round functions for the streaming sha-256 core
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned NumWord = 8;
    localparam int unsigned BlkByte = 64;

    localparam logic [7:0]  PadByte = 8'h80;
    localparam logic [5:0]  LenPos  = 6'd56;
    localparam logic [63:0] BlkBits = 64'd512;

    // input kinds carried on tuser
    localparam logic KindAbsorb = 1'b0;
    localparam logic KindFinish = 1'b1;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        big0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        big1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

// File: hdl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// byte-serial sha-256 with block buffer and chain words in on-chip memories
// ----------------------------------------------------------------------------
// absorb beat: the 64th byte of a block also runs
//   the compression: byte load, chain-read, round and chain-update steps in order
// finish beat: writes 0x80, then padding bytes (63 - fill, none when
//   the buffer holds 63 bytes), one or two compressions (64 more pad bytes
//   before the second), a prefetch read, the output beats (one per cycle when
//   m_tready is high), then a reload of the initial hash
// throughput is set by the single round unit (one round per cycle) and the
//   single write port of the byte buffer memory
// reset (aresetn low, synchronous): chain memory is reloaded with the initial hash
//   (no input beat taken meanwhile), fill count and bit count cleared
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero pad
    output logic        m_tlast    // last_word
);

    // sequencer states
    localparam logic [3:0] StInit  = 4'd0;  // write initial hash to chain memory
    localparam logic [3:0] StIdle  = 4'd1;
    localparam logic [3:0] StPad   = 4'd2;  // write zeros / length bytes (0x80 is written by the finish beat)
    localparam logic [3:0] StLoad  = 4'd3;  // read 64 bytes into the schedule
    localparam logic [3:0] StCrd   = 4'd4;  // read chain words into a..h
    localparam logic [3:0] StRound = 4'd5;
    localparam logic [3:0] StUpd   = 4'd6;  // chain += working vars
    localparam logic [3:0] StOut   = 4'd7;

    logic [3:0]  state_reg, state_next;

    // byte buffer memory
    logic [7:0]  buf_mem [64];
    logic        buf_we;
    logic [5:0]  buf_waddr;
    logic [7:0]  buf_wdata;
    logic [5:0]  buf_raddr;
    logic [7:0]  buf_rdata_reg;

    // chain memory
    logic [31:0] chn_mem [8];
    logic        chn_we;
    logic [2:0]  chn_waddr;
    logic [31:0] chn_wdata;
    logic [2:0]  chn_raddr;
    logic [31:0] chn_rdata_reg;

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (chn_we) begin
            chn_mem[chn_waddr] <= chn_wdata;
        end
        chn_rdata_reg <= chn_mem[chn_raddr];
    end

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;   // message length latched at finish
    logic        fin_reg, fin_next;       // in a finish sequence
    logic        second_reg, second_next; // padding spills into a second block
    logic [6:0]  cnt_reg, cnt_next;       // generic step counter
    logic [5:0]  pad_reg, pad_next;       // padding write position
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [2:0]  oidx_reg, oidx_next;
    logic        mval_reg, mval_next;
    logic [31:0] mword_reg, mword_next;

    logic [31:0] t1, t2, wnew;
    logic [7:0]  pad_byte;

    assign s_tready = (state_reg == StIdle);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {5'd0, oidx_reg, mword_reg};
    assign m_tlast  = (oidx_reg == 3'd7);

    // message schedule: next word from the 16-entry window
    assign wnew = sha256_pkg::sig1(w_reg[14]) + w_reg[9]
                + sha256_pkg::sig0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + sha256_pkg::big1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha256_pkg::RoundK[cnt_reg[5:0]] + w_reg[0];
    assign t2 = sha256_pkg::big0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // padding byte at position pad_reg
    always_comb begin
        if (second_reg || pad_reg < sha256_pkg::LenPos) begin
            pad_byte = 8'h00;
        end else begin
            pad_byte = total_reg[8 * (63 - pad_reg) +: 8];
        end
    end

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        total_next  = total_reg;
        fin_next    = fin_reg;
        second_next = second_reg;
        cnt_next    = cnt_reg;
        pad_next    = pad_reg;
        w_next      = w_reg;
        v_next      = v_reg;
        oidx_next   = oidx_reg;
        mval_next   = mval_reg;
        mword_next  = mword_reg;
        buf_we      = 1'b0;
        buf_waddr   = fill_reg;
        buf_wdata   = s_tdata;
        buf_raddr   = cnt_reg[5:0];
        chn_we      = 1'b0;
        chn_waddr   = cnt_reg[2:0];
        chn_wdata   = sha256_pkg::InitHash[cnt_reg[2:0]];
        chn_raddr   = cnt_reg[2:0];

        case (state_reg)
            StInit: begin
                chn_we   = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd7) begin
                    cnt_next   = '0;
                    fill_next  = '0;
                    bits_next  = '0;
                    fin_next   = 1'b0;
                    state_next = StIdle;
                end
            end
            StIdle: begin
                cnt_next = '0;
                if (s_tvalid) begin
                    if (s_tuser == sha256_pkg::KindAbsorb) begin
                        buf_we    = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            fin_next   = 1'b0;
                            state_next = StLoad;
                        end
                    end else begin
                        total_next = bits_reg + {55'd0, fill_reg, 3'd0};
                        buf_we     = 1'b1;
                        buf_wdata  = sha256_pkg::PadByte;
                        second_next = (fill_reg > 6'd55);
                        pad_next   = fill_reg + 6'd1;
                        fin_next   = 1'b1;
                        state_next = (fill_reg == 6'd63) ? StLoad : StPad;
                    end
                end
            end
            StPad: begin
                buf_we    = 1'b1;
                buf_waddr = pad_reg;
                buf_wdata = pad_byte;
                pad_next  = pad_reg + 6'd1;
                if (pad_reg == 6'd63) begin
                    cnt_next   = '0;
                    state_next = StLoad;
                end
            end
            StLoad: begin
                // read byte cnt, data arrives in the next cycle
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0) begin
                    w_next[15] = {w_reg[15][23:0], buf_rdata_reg};
                    // first byte of each word opens a new window slot
                    if (cnt_reg[1:0] == 2'd1) begin
                        for (int i = 0; i < 15; i++) w_next[i] = w_reg[i + 1];
                        w_next[15] = {24'd0, buf_rdata_reg};
                    end
                end
                if (cnt_reg == 7'd63) begin
                    cnt_next   = '0;
                    state_next = StCrd;
                end
            end
            StCrd: begin
                // last byte of the block arrives here
                if (cnt_reg == 7'd0) begin
                    w_next[15] = {w_reg[15][23:0], buf_rdata_reg};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0) begin
                    v_next[3'(cnt_reg - 7'd1)] = chn_rdata_reg;
                end
                if (cnt_reg == 7'd8) begin
                    cnt_next   = '0;
                    state_next = StRound;
                end
            end
            StRound: begin
                for (int i = 0; i < 15; i++) w_next[i] = w_reg[i + 1];
                w_next[15] = wnew;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    cnt_next   = '0;
                    state_next = StUpd;
                end
            end
            StUpd: begin
                // chain word k is read, then written back plus v[k] once its read data is back
                chn_raddr = cnt_reg[2:0];
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0) begin
                    chn_we    = 1'b1;
                    chn_waddr = 3'(cnt_reg - 7'd1);
                    chn_wdata = chn_rdata_reg + v_reg[3'(cnt_reg - 7'd1)];
                end
                if (cnt_reg == 7'd8) begin
                    cnt_next = '0;
                    if (!fin_reg) begin
                        bits_next  = bits_reg + sha256_pkg::BlkBits;
                        fill_next  = '0;
                        state_next = StIdle;
                    end else if (second_reg) begin
                        second_next = 1'b0;
                        pad_next    = '0;
                        state_next  = StPad;
                    end else begin
                        state_next = StOut;
                    end
                end
            end
            StOut: begin
                // prefetch word cnt; present it once read data is back
                // while stalled, keep reading the word that goes out next
                chn_raddr = 3'(cnt_reg - 7'd1);
                if (cnt_reg == 7'd0) begin
                    chn_raddr = 3'd0;
                    cnt_next  = 7'd1;
                end else if (!mval_reg || m_tready) begin
                    if (mval_reg && oidx_reg == 3'd7) begin
                        mval_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = StInit;
                    end else begin
                        mval_next  = 1'b1;
                        mword_next = chn_rdata_reg;
                        oidx_next  = 3'(cnt_reg - 7'd1);
                        chn_raddr  = cnt_reg[2:0];
                        if (cnt_reg != 7'd8) cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            default: state_next = StInit;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StInit;
            cnt_reg    <= '0;
            fill_reg   <= '0;
            bits_reg   <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            mval_reg   <= 1'b0;
            oidx_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            fin_reg    <= fin_next;
            second_reg <= second_next;
            mval_reg   <= mval_next;
            oidx_reg   <= oidx_next;
        end
        total_reg <= total_next;
        pad_reg   <= pad_next;
        w_reg     <= w_next;
        v_reg     <= v_next;
        mword_reg <= mword_next;
    end

endmodule

// File: hdl/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// port-level checks for the streaming sha-256 core
// ----------------------------------------------------------------------------
module sha256_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // input is never taken while a digest is being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready during output");

    // last flag marks word seven only
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("bad last");

    // word index steps by one after each accepted non-last beat
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
        m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)) else $error("index skip");

    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("drop");

endmodule

bind sha256_stream_hasher_core sha256_checker u_sha256_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// File: sim/sha256_stream_hasher_core_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core_tb
// streams byte messages into the hasher, predicts each digest with a local
// sha-256 model and checks every output beat in order
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } hash_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha256_stream_hasher_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor state
    logic [31:0] hash_h [8];
    logic [7:0]  msg_buf [64];
    int unsigned msg_fill;
    logic [63:0] bits_done;

    hash_in_t     pending_beats [$];
    digest_beat_t digest_queue [$];
    int  fails = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_send = 1'b0;
    int  quiet_cycles = 0;

    const logic [31:0] k_tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    const logic [31:0] iv_tab [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_buf into hash_h
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_h[i] = iv_tab[i];
        msg_fill = 0;
        bits_done = '0;
    endtask

    // advance the predictor by one accepted input beat
    task automatic predict_digest(hash_in_t it);
        int unsigned pos;
        logic [63:0] total;
        if (it.kind == sha256_pkg::KindAbsorb) begin
            msg_buf[msg_fill] = it.data_byte;
            msg_fill++;
            if (msg_fill == 64) begin
                compress_block();
                bits_done += 64'd512;
                msg_fill = 0;
            end
        end else begin
            pos = msg_fill;
            total = bits_done + 64'(pos) * 8;
            msg_buf[pos] = 8'h80;
            pos++;
            // long tail: padding spills into an extra block
            if (pos > 56) begin
                while (pos < 64) begin msg_buf[pos] = 8'h00; pos++; end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin msg_buf[pos] = 8'h00; pos++; end
            for (int i = 0; i < 8; i++) msg_buf[63-i] = total[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
                digest_queue.push_back('{hash_h[i], 3'(i), 1'(i == 7)});
            restart_hash();
        end
    endtask

    task automatic queue_message(int len, bit rand_bytes, logic [7:0] fill);
        for (int i = 0; i < len; i++)
            pending_beats.push_back('{sha256_pkg::KindAbsorb,
                rand_bytes ? 8'($urandom_range(0, 255)) : fill});
        // finish carries random data that must be ignored
        pending_beats.push_back('{sha256_pkg::KindFinish, 8'($urandom_range(0, 255))});
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // driver: present the head of the pending queue, idling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_beats.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= pending_beats.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // prediction on each accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            predict_digest('{s_tuser, s_tdata});
    end

    // monitor: random stalls, compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        digest_beat_t exp_b;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected output beat %h", m_tdata);
                    fails++;
                end else begin
                    exp_b = digest_queue.pop_front();
                    if (m_tdata[31:0] !== exp_b.digest_word) begin
                        $error("digest_word exp %h got %h", exp_b.digest_word, m_tdata[31:0]);
                        fails++;
                    end
                    if (m_tdata[34:32] !== exp_b.word_index) begin
                        $error("word_index exp %0d got %0d", exp_b.word_index,
                               m_tdata[34:32]);
                        fails++;
                    end
                    if (m_tlast !== exp_b.last_word) begin
                        $error("last_word exp %0d got %0d", exp_b.last_word, m_tlast);
                        fails++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("sha256_stream_hasher_core verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_tvalid || digest_queue.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int len;
        restart_hash();
        for (int i = 0; i < 64; i++) msg_buf[i] = 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty message, zero and all-ones bytes
        queue_message(0, 1'b0, 8'h00);
        queue_message(3, 1'b0, 8'hff);
        queue_message(1, 1'b0, 8'h00);
        // pause until drained
        wait_drained();

        // four stall phases, one long message each (55, 56, 63, then 64 to 72 bytes) and two short ones
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  len = 55; end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  len = 56; end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; len = 63; end
                default: begin
                    send_idle_pct = 10; recv_stall_pct = 10;
                    len = $urandom_range(64, 72);
                end
            endcase
            queue_message(len, 1'b1, 8'h00);
            for (int m = 0; m < 2; m++) begin
                len = $urandom_range(0, 6);
                queue_message(len, 1'b1, 8'h00);
            end
            wait_drained();
        end

        repeat (200) @(posedge aclk);
        if (fails == 0)
            $display("sha256_stream_hasher_core verification clean");
        else
            $display("sha256_stream_hasher_core verification failed");
        $finish;
    end
endmodule
